### rtl/indexed_list_engine_macros.svh
// assertion macros for the indexed list engine
// used by indexed_list_engine.sv, expects clk and rst_n in scope
`ifndef INDEXED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LIST_ENGINE_MACROS_SVH

// same-cycle implication
`define ILE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ILE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ile_pkg.sv
// types and codes for the indexed list engine
// no dependencies
package ile_pkg;

  localparam logic [2:0] OP_ADD_TAIL  = 3'd0;
  localparam logic [2:0] OP_ADD_HEAD  = 3'd1;
  localparam logic [2:0] OP_TAKE_HEAD = 3'd2;
  localparam logic [2:0] OP_TAKE_TAIL = 3'd3;
  localparam logic [2:0] OP_REMOVE    = 3'd4;
  localparam logic [2:0] OP_READ      = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  position;
    logic [31:0] value;
  } ile_in_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [1:0]  status;
    logic [4:0]  entry_count;
  } ile_out_t;

endpackage

### rtl/indexed_list_engine.sv
// indexed list engine top level: bounded deque with indexed access
// depends on ile_pkg and indexed_list_engine_macros.svh
//
// Keeps an ordered list of up to CAPACITY words, position 0 at the front.
// An operation is taken whenever start is high (busy never rises), so one
// operation is accepted every cycle. Each operation gives exactly one
// result beat, marked by out_valid for one cycle; the receiver cannot
// stall, so it must take every beat as it comes. The beat passes the
// input register and the list update: all entries shift in parallel,
// and that single update of the register list sets the one-per-cycle
// rate. Errors (empty list, position out of range, push to a full list)
// are reported in status and leave the list unchanged.
module indexed_list_engine
  import ile_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ile_in_t  in_data,
  output logic     out_valid,
  output ile_out_t out_data
);

`include "indexed_list_engine_macros.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

  // input register
  logic     in_valid_r;
  ile_in_t  in_r;

  // list state
  logic [VALUE_WIDTH-1:0] entries_r [CAPACITY];
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;

  // result register
  logic     out_valid_r;
  ile_out_t out_r;
  ile_out_t out_nxt;

  // decoded operation
  logic                   do_add_tail;
  logic                   do_add_head;
  logic                   do_remove;
  logic                   push_ok;
  logic [IDX_W-1:0]       rm_idx;
  logic [IDX_W-1:0]       rd_idx;
  logic [VALUE_WIDTH-1:0] push_val;
  logic [VALUE_WIDTH-1:0] rd_data;
  logic [63:0]            val_wide;
  logic [63:0]            rd_wide;
  logic [CMP_W-1:0]       pos_wide;
  logic [CMP_W-1:0]       cnt_wide;
  logic                   is_empty;
  logic                   is_full;

  // operations are never held off
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      in_r <= in_data;
    end
  end

  // word stored by a push, kept to the storage width
  assign val_wide = {32'd0, in_r.value};
  assign push_val = val_wide[VALUE_WIDTH-1:0];

  assign pos_wide = CMP_W'(in_r.position);
  assign cnt_wide = CMP_W'(count_r);
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r >= CNT_W'(CAPACITY));

  // single read port into the list
  assign rd_data = entries_r[rd_idx];
  assign rd_wide = 64'(rd_data);

  always_comb begin
    do_add_tail = 1'b0;
    do_add_head = 1'b0;
    do_remove   = 1'b0;
    rm_idx      = '0;
    rd_idx      = '0;
    count_nxt   = count_r;
    out_nxt.result_value = '0;
    out_nxt.status       = ST_OK;
    unique case (in_r.op)
      OP_ADD_TAIL, OP_ADD_HEAD: begin
        if (is_full) begin
          out_nxt.status = ST_FULL;
        end else begin
          do_add_tail = (in_r.op == OP_ADD_TAIL);
          do_add_head = (in_r.op == OP_ADD_HEAD);
          count_nxt   = count_r + CNT_W'(1);
        end
      end
      OP_TAKE_HEAD, OP_TAKE_TAIL: begin
        // front takes position 0, back the last valid position
        rm_idx = (in_r.op == OP_TAKE_TAIL) ? IDX_W'(count_r - CNT_W'(1)) : '0;
        rd_idx = rm_idx;
        if (is_empty) begin
          out_nxt.status = ST_EMPTY;
        end else begin
          do_remove            = 1'b1;
          count_nxt            = count_r - CNT_W'(1);
          out_nxt.result_value = rd_wide[31:0];
        end
      end
      OP_REMOVE, OP_READ: begin
        rm_idx = pos_wide[IDX_W-1:0];
        rd_idx = rm_idx;
        if (is_empty) begin
          out_nxt.status = ST_EMPTY;
        end else if (pos_wide >= cnt_wide) begin
          out_nxt.status = ST_RANGE;
        end else begin
          out_nxt.result_value = rd_wide[31:0];
          if (in_r.op == OP_REMOVE) begin
            do_remove = 1'b1;
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      default: begin
        // unused codes do nothing
      end
    endcase
    out_nxt.entry_count = 5'(count_nxt);
  end

  // an accepted push that finds room
  assign push_ok = in_valid_r && (do_add_tail || do_add_head);

  // every entry updates in parallel from its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_entry
    logic                   wr_en;
    logic [VALUE_WIDTH-1:0] wr_data;

    always_comb begin
      wr_en   = 1'b0;
      wr_data = push_val;
      if (in_valid_r) begin
        if (do_add_tail && (CNT_W'(i) == count_r)) begin
          wr_en = 1'b1;
        end else if (do_add_head) begin
          // front push moves everything one place back
          wr_en = 1'b1;
          if (i > 0) begin
            wr_data = entries_r[(i > 0) ? i - 1 : 0];
          end
        end else if (do_remove && (IDX_W'(i) >= rm_idx) && (i < CAPACITY - 1)) begin
          // removal closes the gap toward the front
          wr_en   = 1'b1;
          wr_data = entries_r[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (wr_en) begin
        entries_r[i] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // every accepted operation yields a result beat in the cycle after decode
  `ILE_ASSERT_NXT(a_beat_follows, in_valid_r, out_valid_r, "result beat missing")
  // the list never holds more than its capacity
  `ILE_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY), "count above capacity")
  // a full status only goes out while the list is full
  `ILE_ASSERT_IMP(a_full_st, out_valid_r && out_r.status == ST_FULL, is_full, "full with room")
  // an accepted push grows the list by one
  `ILE_ASSERT_NXT(a_push_grow, push_ok, count_r == $past(count_r) + CNT_W'(1), "no growth")

endmodule
